### rtl/ags_pkg.sv
package ags_pkg;

  localparam int MAX_GRID_WIDTH  = 256;
  localparam int MAX_GRID_HEIGHT = 256;
  localparam int FRAC_BITS       = 16;
  localparam int KERNEL_SHIFT    = 20;
  localparam int LOSS_SHIFT      = 16;

  localparam int VAL_W   = 32;
  localparam int SOLID_W = 8;
  localparam int SIZE_W  = 9;
  localparam int LOSS_W  = 17;
  localparam int GAIN_W  = 32;

  localparam int COL_W  = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W  = $clog2(MAX_GRID_HEIGHT);
  localparam int WDIM_W = $clog2(MAX_GRID_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_GRID_HEIGHT + 1);

  localparam int AC_W    = VAL_W + 1;
  localparam int SUM_W   = VAL_W + 3;
  localparam int DIFF_W  = VAL_W + 2;
  localparam int ACC_W   = SUM_W + 21;
  localparam int GPROD_W = DIFF_W + GAIN_W;
  localparam int GTERM_W = GPROD_W - FRAC_BITS;
  localparam int LPROD_W = VAL_W + LOSS_W + 1;
  localparam int LTERM_W = LPROD_W - LOSS_SHIFT;
  localparam int RES_W   = GTERM_W + 1;

  localparam int W_CORNER = 11895;
  localparam int W_EDGE   = 87891;
  localparam int W_CENTRE = 649432;

  localparam int KERNEL_HALF = 1 << (KERNEL_SHIFT - 1);
  localparam int FRAC_HALF   = 1 << (FRAC_BITS - 1);
  localparam int LOSS_HALF   = 1 << (LOSS_SHIFT - 1);

  localparam int NUM_FIELDS = 3;
  localparam int F_VX = 0;
  localparam int F_VY = 1;
  localparam int F_P  = 2;

  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_LOSS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_LOSS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VELOCITY_GAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PRESSURE_GAIN = 3'd5;

  typedef logic [NUM_FIELDS-1:0][VAL_W-1:0] trip_t;

  typedef struct packed {
    trip_t              v;
    logic [SOLID_W-1:0] solid;
  } px_t;

  typedef struct packed {
    trip_t top;
    px_t   mid;
    trip_t bot;
  } column_t;

  typedef struct packed {
    logic [NUM_FIELDS-1:0][AC_W-1:0]  ac;
    logic [NUM_FIELDS-1:0][VAL_W-1:0] b;
  } csum_t;

  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } meta_t;

  typedef struct packed {
    logic [LOSS_W-1:0] velocity_loss;
    logic [LOSS_W-1:0] pressure_loss;
    logic [GAIN_W-1:0] velocity_gain;
    logic [GAIN_W-1:0] pressure_gain;
  } cfg_t;

endpackage

### rtl/ags_line_buffer.sv
module ags_line_buffer (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [ags_pkg::COL_W-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [ags_pkg::COL_W-1:0] wr_addr_i,
  input  ags_pkg::px_t             wr_px_i,
  output ags_pkg::px_t             row1_o,
  output ags_pkg::trip_t           row2_o
);
  import ags_pkg::*;

  // Row one above the newest cell, and row two above it.
  px_t   mem_a [MAX_GRID_WIDTH];
  trip_t mem_b [MAX_GRID_WIDTH];
  px_t   rd_a_q;
  trip_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_a[rd_addr_i];
      rd_b_q <= mem_b[rd_addr_i];
    end
  end

  // The value leaving the row-one store moves down into the row-two store.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_px_i;
      mem_b[wr_addr_i] <= rd_a_q.v;
    end
  end

  assign row1_o = rd_a_q;
  assign row2_o = rd_b_q;

endmodule

### rtl/ags_cell.sv
module ags_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  ags_pkg::column_t col_i,
  input  logic             top_ok_i,
  input  logic             bot_ok_i,
  input  logic             col_ok_i,
  output ags_pkg::column_t col_o,
  output ags_pkg::csum_t   sum_o
);
  import ags_pkg::*;

  column_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Off-grid neighbours contribute nothing to the weighted sums.
  always_comb begin
    logic signed [AC_W-1:0] t;
    logic signed [AC_W-1:0] u;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      t = (top_ok_i && col_ok_i) ? AC_W'($signed(col_q.top[f])) : '0;
      u = (bot_ok_i && col_ok_i) ? AC_W'($signed(col_q.bot[f])) : '0;
      sum_o.ac[f] = t + u;
      sum_o.b[f]  = col_ok_i ? col_q.mid.v[f] : '0;
    end
  end

  assign col_o = col_q;

endmodule

### rtl/ags_update.sv
module ags_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  ags_pkg::column_t           win_i [3],
  input  ags_pkg::csum_t             sum_i [3],
  input  ags_pkg::meta_t             meta_i,
  input  ags_pkg::cfg_t              cfg_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [ags_pkg::VAL_W-1:0]  out_velocity_x_o,
  output logic [ags_pkg::VAL_W-1:0]  out_velocity_y_o,
  output logic [ags_pkg::VAL_W-1:0]  out_pressure_o,
  output logic [ags_pkg::SOLID_W-1:0] out_solid_type_o,
  output logic                       frame_last_o,
  output logic                       busy_o
);
  import ags_pkg::*;

  logic v3_q, v4_q, v5_q, v6_q, out_valid_q, load;

  logic signed [SUM_W-1:0]   sc_q [NUM_FIELDS];
  logic signed [SUM_W-1:0]   se_q [NUM_FIELDS];
  logic signed [VAL_W-1:0]   scen_q [NUM_FIELDS];
  logic signed [DIFF_W-1:0]  diff_q [NUM_FIELDS];
  logic signed [ACC_W-1:0]   ksum_q [NUM_FIELDS];
  logic signed [GPROD_W-1:0] gprod_q [NUM_FIELDS];
  logic signed [VAL_W-1:0]   avg_q [NUM_FIELDS];
  logic signed [GTERM_W-1:0] gterm_q [NUM_FIELDS];
  logic signed [LPROD_W-1:0] lprod_q [NUM_FIELDS];
  logic [SOLID_W-1:0]        solid_q;
  logic                      last_q;
  logic [VAL_W-1:0]          res_d [NUM_FIELDS];
  logic [VAL_W-1:0]          res_q [NUM_FIELDS];
  logic [SOLID_W-1:0]        out_solid_q;
  logic                      out_last_q;

  logic signed [DIFF_W-1:0] hdiff_p, vdiff_p, hdiff_vx, vdiff_vy;

  always_comb begin
    hdiff_p  = '0;
    hdiff_vx = '0;
    vdiff_p  = '0;
    vdiff_vy = '0;
    if (meta_i.left_ok && meta_i.right_ok) begin
      hdiff_p  = DIFF_W'($signed(win_i[0].mid.v[F_P])) - DIFF_W'($signed(win_i[2].mid.v[F_P]));
      hdiff_vx = DIFF_W'($signed(win_i[0].mid.v[F_VX]))
               - DIFF_W'($signed(win_i[2].mid.v[F_VX]));
    end
    if (meta_i.top_ok && meta_i.bot_ok) begin
      vdiff_p  = DIFF_W'($signed(win_i[1].bot[F_P])) - DIFF_W'($signed(win_i[1].top[F_P]));
      vdiff_vy = DIFF_W'($signed(win_i[1].bot[F_VY])) - DIFF_W'($signed(win_i[1].top[F_VY]));
    end
  end

  // Window capture: column sums of the three cells and the central differences.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        sc_q[f]   <= SUM_W'($signed(sum_i[0].ac[f])) + SUM_W'($signed(sum_i[2].ac[f]));
        se_q[f]   <= SUM_W'($signed(sum_i[0].b[f])) + SUM_W'($signed(sum_i[2].b[f]))
                   + SUM_W'($signed(sum_i[1].ac[f]));
        scen_q[f] <= $signed(sum_i[1].b[f]);
      end
      diff_q[F_VX] <= hdiff_p;
      diff_q[F_VY] <= vdiff_p;
      diff_q[F_P]  <= vdiff_vy + hdiff_vx;
      solid_q      <= win_i[1].mid.solid;
      last_q       <= meta_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        ksum_q[f] <= ACC_W'(sc_q[f]) * ACC_W'(W_CORNER)
                   + ACC_W'(se_q[f]) * ACC_W'(W_EDGE)
                   + ACC_W'(scen_q[f]) * ACC_W'(W_CENTRE);
        gprod_q[f] <= GPROD_W'(diff_q[f])
                    * GPROD_W'($signed((f == F_P) ? cfg_i.pressure_gain : cfg_i.velocity_gain));
      end
    end
  end

  logic signed [ACC_W-1:0]   kround [NUM_FIELDS];
  logic signed [GPROD_W-1:0] ground [NUM_FIELDS];

  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      kround[f] = ksum_q[f] + ACC_W'(KERNEL_HALF);
      ground[f] = gprod_q[f] + GPROD_W'(FRAC_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        avg_q[f]   <= kround[f][KERNEL_SHIFT+VAL_W-1:KERNEL_SHIFT];
        gterm_q[f] <= ground[f][GPROD_W-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v5_q) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        lprod_q[f] <= LPROD_W'(avg_q[f]) * LPROD_W'($signed({1'b0,
                      (f == F_P) ? cfg_i.pressure_loss : cfg_i.velocity_loss}));
      end
    end
  end

  // Loss term minus gain term, saturated to the value width; a solid cell gives zero.
  always_comb begin
    logic signed [LPROD_W-1:0] lr;
    logic signed [LTERM_W-1:0] lt;
    logic signed [RES_W-1:0]   r;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      lr = lprod_q[f] + LPROD_W'(LOSS_HALF);
      lt = lr[LPROD_W-1:LOSS_SHIFT];
      r  = RES_W'(lt) - RES_W'(gterm_q[f]);
      if (solid_q != '0) begin
        res_d[f] = '0;
      end else if (r[RES_W-1:VAL_W-1] == '0 || r[RES_W-1:VAL_W-1] == '1) begin
        res_d[f] = r[VAL_W-1:0];
      end else if (r[RES_W-1]) begin
        res_d[f] = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        res_d[f] = {1'b0, {(VAL_W-1){1'b1}}};
      end
    end
  end

  assign load = v6_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v3_q        <= start_i;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q || (v6_q && !load);
      out_valid_q <= load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        res_q[f] <= res_d[f];
      end
      out_solid_q <= solid_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_velocity_x_o = res_q[F_VX];
  assign out_velocity_y_o = res_q[F_VY];
  assign out_pressure_o   = res_q[F_P];
  assign out_solid_type_o = out_solid_q;
  assign frame_last_o     = out_last_q;
  assign busy_o           = v3_q || v4_q || v5_q || v6_q;

endmodule

### rtl/air_grid_stencil_update.sv
// Air grid stencil update.
// The input channel takes the previous air grid in raster order, one cell per
// item (command cell), or a flush item that drains one pending result after
// the whole grid has arrived. The output channel gives the new cell values with
// the solid type and a flag on the final cell of the grid. Results lag the
// input by one row plus one cell; the last row plus one cell of a grid come out
// on flush items. A flush with nothing pending does not occupy the block and
// gives no result.
// An item that gives a result occupies the block until its result leaves the
// last stage: one line-store read, one shift of the three-column cell chain,
// then five stages of kernel sums, multiplies, rounding and saturation. A cell
// of the first row, or the first cell of the second row, gives no result and
// occupies the block only for the line-store read and the chain shift.
// If the receiver stalls, one result waits in the output register and the
// next item may still be taken; its result waits in the last stage until the
// output register is free.
// Reset clears the counters and the configuration (256 by 256 grid, unity
// losses, zero gains). The line stores are not cleared; entries outside the
// grid are masked. Writing the grid width or height restarts the frame.
module air_grid_stencil_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [ags_pkg::VAL_W-1:0]     in_velocity_x_i,
  input  logic [ags_pkg::VAL_W-1:0]     in_velocity_y_i,
  input  logic [ags_pkg::VAL_W-1:0]     in_pressure_i,
  input  logic [ags_pkg::SOLID_W-1:0]   in_solid_type_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ags_pkg::VAL_W-1:0]     out_velocity_x_o,
  output logic [ags_pkg::VAL_W-1:0]     out_velocity_y_o,
  output logic [ags_pkg::VAL_W-1:0]     out_pressure_o,
  output logic [ags_pkg::SOLID_W-1:0]   out_solid_type_o,
  output logic                          frame_last_o
);
  import ags_pkg::*;

  logic [SIZE_W-1:0] grid_width_q, grid_height_q;
  logic [LOSS_W-1:0] velocity_loss_q, pressure_loss_q;
  logic [GAIN_W-1:0] velocity_gain_q, pressure_gain_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr, size_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign size_wr = cfg_wr && (reg_idx == REG_GRID_WIDTH || reg_idx == REG_GRID_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q    <= SIZE_W'(256);
      grid_height_q   <= SIZE_W'(256);
      velocity_loss_q <= LOSS_W'(65536);
      pressure_loss_q <= LOSS_W'(65536);
      velocity_gain_q <= '0;
      pressure_gain_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRID_WIDTH:    grid_width_q    <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT:   grid_height_q   <= pwdata[SIZE_W-1:0];
        REG_VELOCITY_LOSS: velocity_loss_q <= pwdata[LOSS_W-1:0];
        REG_PRESSURE_LOSS: pressure_loss_q <= pwdata[LOSS_W-1:0];
        REG_VELOCITY_GAIN: velocity_gain_q <= pwdata[GAIN_W-1:0];
        REG_PRESSURE_GAIN: pressure_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:    prdata = 32'(grid_width_q);
      REG_GRID_HEIGHT:   prdata = 32'(grid_height_q);
      REG_VELOCITY_LOSS: prdata = 32'(velocity_loss_q);
      REG_PRESSURE_LOSS: prdata = 32'(pressure_loss_q);
      REG_VELOCITY_GAIN: prdata = velocity_gain_q;
      REG_PRESSURE_GAIN: prdata = pressure_gain_q;
      default:           prdata = '0;
    endcase
  end

  logic [WDIM_W-1:0] w_used;
  logic [HDIM_W-1:0] h_used;

  always_comb begin
    if (grid_width_q < 3) begin
      w_used = WDIM_W'(3);
    end else if (grid_width_q > MAX_GRID_WIDTH) begin
      w_used = WDIM_W'(MAX_GRID_WIDTH);
    end else begin
      w_used = WDIM_W'(grid_width_q);
    end
    if (grid_height_q < 3) begin
      h_used = HDIM_W'(3);
    end else if (grid_height_q > MAX_GRID_HEIGHT) begin
      h_used = HDIM_W'(MAX_GRID_HEIGHT);
    end else begin
      h_used = HDIM_W'(grid_height_q);
    end
  end

  // Frame position of the next input cell and of the next result.
  logic [COL_W-1:0]  col_q, col_d, ocol_q, ocol_d, cur_col, cur_ocol;
  logic [ROW_W-1:0]  row_q, row_d, cur_row;
  logic [HDIM_W-1:0] orow_q, orow_d, cur_orow;
  logic              frame_q, frame_d;
  logic              accept, restart, push, emit, col_wrap, ocol_wrap;
  logic              s1_q, s2_q, upd_busy;
  meta_t             meta_d, meta_q;
  px_t               in_px, in_q;
  logic [COL_W-1:0]  addr_q;

  assign in_ready_o = !(s1_q || s2_q || upd_busy);
  assign accept     = in_valid_i && in_ready_o;
  assign restart    = accept && (command_i == CMD_CELL) && frame_q;

  always_comb begin
    cur_col   = restart ? '0 : col_q;
    cur_row   = restart ? '0 : row_q;
    cur_ocol  = restart ? '0 : ocol_q;
    cur_orow  = restart ? '0 : orow_q;
    col_wrap  = (WDIM_W'(cur_col) + WDIM_W'(1)) == w_used;
    ocol_wrap = (WDIM_W'(cur_ocol) + WDIM_W'(1)) == w_used;

    if (command_i == CMD_CELL) begin
      push = 1'b1;
      emit = (cur_row > ROW_W'(1)) || (cur_row == ROW_W'(1) && cur_col != '0);
    end else begin
      push = frame_q && (cur_orow < h_used);
      emit = push;
    end

    col_d   = cur_col;
    row_d   = cur_row;
    ocol_d  = cur_ocol;
    orow_d  = cur_orow;
    frame_d = restart ? 1'b0 : frame_q;

    if (accept && push) begin
      col_d = col_wrap ? '0 : cur_col + COL_W'(1);
      if (command_i == CMD_CELL && col_wrap) begin
        if ((HDIM_W'(cur_row) + HDIM_W'(1)) == h_used) begin
          row_d   = '0;
          frame_d = 1'b1;
        end else begin
          row_d = cur_row + ROW_W'(1);
        end
      end
    end
    if (accept && emit) begin
      ocol_d = ocol_wrap ? '0 : cur_ocol + COL_W'(1);
      orow_d = ocol_wrap ? cur_orow + HDIM_W'(1) : cur_orow;
    end
    if (size_wr) begin
      col_d   = '0;
      row_d   = '0;
      ocol_d  = '0;
      orow_d  = '0;
      frame_d = 1'b0;
    end

    meta_d.emit     = emit;
    meta_d.top_ok   = cur_orow != '0;
    meta_d.bot_ok   = (cur_orow + HDIM_W'(1)) < h_used;
    meta_d.left_ok  = cur_ocol != '0;
    meta_d.right_ok = !ocol_wrap;
    meta_d.last     = ((cur_orow + HDIM_W'(1)) == h_used) && ocol_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      frame_q <= 1'b0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      frame_q <= frame_d;
      s1_q    <= accept && push;
      s2_q    <= s1_q && meta_q.emit;
    end
  end

  assign in_px.v[F_VX] = in_velocity_x_i;
  assign in_px.v[F_VY] = in_velocity_y_i;
  assign in_px.v[F_P]  = in_pressure_i;
  assign in_px.solid   = in_solid_type_i;

  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      in_q   <= in_px;
      addr_q <= cur_col;
      meta_q <= meta_d;
    end
  end

  px_t   row1;
  trip_t row2;

  ags_line_buffer u_line_buffer (
    .clk_i     (clk_i),
    .rd_en_i   (accept && push),
    .rd_addr_i (cur_col),
    .wr_en_i   (s1_q),
    .wr_addr_i (addr_q),
    .wr_px_i   (in_q),
    .row1_o    (row1),
    .row2_o    (row2)
  );

  // Cell 0 holds the newest column (right of centre), cell 2 the oldest.
  column_t chain [4];
  column_t win [3];
  csum_t   sums [3];
  logic    col_ok [3];

  assign chain[0].top = row2;
  assign chain[0].mid = row1;
  assign chain[0].bot = in_q.v;
  assign col_ok[0]    = meta_q.right_ok;
  assign col_ok[1]    = 1'b1;
  assign col_ok[2]    = meta_q.left_ok;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    ags_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (s1_q),
      .col_i    (chain[k]),
      .top_ok_i (meta_q.top_ok),
      .bot_ok_i (meta_q.bot_ok),
      .col_ok_i (col_ok[k]),
      .col_o    (chain[k+1]),
      .sum_o    (sums[k])
    );
    assign win[k] = chain[k+1];
  end

  cfg_t cfg;
  assign cfg.velocity_loss = velocity_loss_q;
  assign cfg.pressure_loss = pressure_loss_q;
  assign cfg.velocity_gain = velocity_gain_q;
  assign cfg.pressure_gain = pressure_gain_q;

  ags_update u_update (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (s2_q),
    .win_i            (win),
    .sum_i            (sums),
    .meta_i           (meta_q),
    .cfg_i            (cfg),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_velocity_x_o (out_velocity_x_o),
    .out_velocity_y_o (out_velocity_y_o),
    .out_pressure_o   (out_pressure_o),
    .out_solid_type_o (out_solid_type_o),
    .frame_last_o     (frame_last_o),
    .busy_o           (upd_busy)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ags_pkg::*;

  typedef struct {
    logic [VAL_W-1:0]   vx;
    logic [VAL_W-1:0]   vy;
    logic [VAL_W-1:0]   p;
    logic [SOLID_W-1:0] solid;
    logic               last;
  } air_cell_t;

  localparam int ROWS_KEPT   = 3;
  localparam int LIMIT_CYCLES = 600000;

  // Software model of the stencil: three row stores, counters and the register file.
  class air_update_board;
    longint        keep_vx[ROWS_KEPT*MAX_GRID_WIDTH];
    longint        keep_vy[ROWS_KEPT*MAX_GRID_WIDTH];
    longint        keep_p[ROWS_KEPT*MAX_GRID_WIDTH];
    bit [7:0]      keep_solid[ROWS_KEPT*MAX_GRID_WIDTH];
    int            width_reg, height_reg;
    longint        vel_loss, prs_loss, vel_gain, prs_gain;
    int            in_col, in_row, out_col, out_row;
    bit            whole_frame;
    air_cell_t     expected_cells[$];
    int            errors, results_seen;

    function new();
      width_reg = 256; height_reg = 256;
      vel_loss = 65536; prs_loss = 65536; vel_gain = 0; prs_gain = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; whole_frame = 0;
    endfunction

    function int grid_w();
      return width_reg < 3 ? 3 : (width_reg > MAX_GRID_WIDTH ? MAX_GRID_WIDTH : width_reg);
    endfunction

    function int grid_h();
      return height_reg < 3 ? 3 : (height_reg > MAX_GRID_HEIGHT ? MAX_GRID_HEIGHT : height_reg);
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_GRID_WIDTH: begin
          width_reg = value[8:0]; restart();
        end
        REG_GRID_HEIGHT: begin
          height_reg = value[8:0]; restart();
        end
        REG_VELOCITY_LOSS: vel_loss = value[16:0];
        REG_PRESSURE_LOSS: prs_loss = value[16:0];
        REG_VELOCITY_GAIN: vel_gain = longint'($signed(value));
        REG_PRESSURE_GAIN: prs_gain = longint'($signed(value));
        default: ;
      endcase
    endfunction

    function int slot(int r, int c);
      return (r % ROWS_KEPT) * MAX_GRID_WIDTH + (c % MAX_GRID_WIDTH);
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint gain_term(longint diff, longint gain);
      longint lo, hi;
      lo = gain & 64'hFFFF;
      hi = gain >>> FRAC_BITS;
      return diff * hi + round_shift(diff * lo, FRAC_BITS);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void emit_next();
      int        w, h, y, x, k, c;
      longint    ax, ay, ap, dx, dy, dp, wt, rvx, rvy, rp;
      air_cell_t e;
      w = grid_w(); h = grid_h(); y = out_row; x = out_col; c = slot(y, x);
      ax = 0; ay = 0; ap = 0; dx = 0; dy = 0; dp = 0; rvx = 0; rvy = 0; rp = 0;
      if (keep_solid[c] == 0) begin
        for (int j = -1; j <= 1; j++) begin
          for (int i = -1; i <= 1; i++) begin
            if (y + j < 0 || y + j >= h || x + i < 0 || x + i >= w) continue;
            k = slot(y + j, x + i);
            wt = (j == 0 && i == 0) ? W_CENTRE : ((j == 0 || i == 0) ? W_EDGE : W_CORNER);
            ax += keep_vx[k] * wt; ay += keep_vy[k] * wt; ap += keep_p[k] * wt;
          end
        end
        ax = round_shift(ax, KERNEL_SHIFT);
        ay = round_shift(ay, KERNEL_SHIFT);
        ap = round_shift(ap, KERNEL_SHIFT);
        if (y > 0 && y + 1 < h) begin
          dp += keep_vy[slot(y + 1, x)] - keep_vy[slot(y - 1, x)];
          dy = keep_p[slot(y + 1, x)] - keep_p[slot(y - 1, x)];
        end
        if (x > 0 && x + 1 < w) begin
          dp += keep_vx[slot(y, x + 1)] - keep_vx[slot(y, x - 1)];
          dx = keep_p[slot(y, x + 1)] - keep_p[slot(y, x - 1)];
        end
        rvx = sat(round_shift(ax * vel_loss, LOSS_SHIFT) - gain_term(dx, vel_gain));
        rvy = sat(round_shift(ay * vel_loss, LOSS_SHIFT) - gain_term(dy, vel_gain));
        rp  = sat(round_shift(ap * prs_loss, LOSS_SHIFT) - gain_term(dp, prs_gain));
      end
      e.vx = rvx[31:0]; e.vy = rvy[31:0]; e.p = rp[31:0];
      e.solid = keep_solid[c];
      e.last = (y + 1 == h && x + 1 == w);
      expected_cells.push_back(e);
      out_col++;
      if (out_col >= w) begin
        out_col = 0; out_row++;
      end
    endfunction

    function void note_item(logic cmd, logic [31:0] vx, logic [31:0] vy, logic [31:0] p,
                            logic [7:0] solid);
      int w, h, c;
      bit ready;
      w = grid_w(); h = grid_h();
      if (cmd == CMD_FLUSH) begin
        if (whole_frame && out_row < h) emit_next();
        return;
      end
      if (whole_frame) restart();
      c = slot(in_row, in_col);
      keep_vx[c] = longint'($signed(vx)); keep_vy[c] = longint'($signed(vy));
      keep_p[c] = longint'($signed(p)); keep_solid[c] = solid;
      ready = in_row > 1 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
        if (in_row >= h) begin
          in_row = 0; whole_frame = 1;
        end
      end
      if (ready) emit_next();
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", field, got, want);
      errors++;
    endtask

    task check_cell(air_cell_t got);
      air_cell_t e;
      results_seen++;
      if (expected_cells.size() == 0) begin
        report("unexpected result, velocity x", got.vx, 32'h0);
        return;
      end
      e = expected_cells.pop_front();
      if (got.vx !== e.vx) report("velocity x", got.vx, e.vx);
      if (got.vy !== e.vy) report("velocity y", got.vy, e.vy);
      if (got.p !== e.p) report("pressure", got.p, e.p);
      if (got.solid !== e.solid) report("solid type", 32'(got.solid), 32'(e.solid));
      if (got.last !== e.last) report("frame last", 32'(got.last), 32'(e.last));
    endtask
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic               command_i = CMD_CELL;
  logic [VAL_W-1:0]   in_velocity_x_i = '0, in_velocity_y_i = '0, in_pressure_i = '0;
  logic [SOLID_W-1:0] in_solid_type_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic [VAL_W-1:0]   out_velocity_x_o, out_velocity_y_o, out_pressure_o;
  logic [SOLID_W-1:0] out_solid_type_o;
  logic               frame_last_o;

  air_update_board board = new();
  int send_idle, recv_idle;
  int items_sent, flushes_sent, cycles;

  air_grid_stencil_update dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timed out after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    air_cell_t got;
    if (rst_ni && in_valid_i && in_ready_o)
      board.note_item(command_i, in_velocity_x_i, in_velocity_y_i, in_pressure_i,
                      in_solid_type_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.vx = out_velocity_x_o; got.vy = out_velocity_y_o; got.p = out_pressure_o;
      got.solid = out_solid_type_o; got.last = frame_last_o;
      board.check_cell(got);
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance.
  task send_item(logic cmd, logic [31:0] vx, logic [31:0] vy, logic [31:0] p,
                 logic [7:0] solid);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    command_i = cmd; in_velocity_x_i = vx; in_velocity_y_i = vy;
    in_pressure_i = p; in_solid_type_i = solid; in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
    if (cmd == CMD_FLUSH) flushes_sent++;
  endtask

  task flush_one();
    send_item(CMD_FLUSH, $urandom, $urandom, $urandom, 8'($urandom));
  endtask

  // Holds the sender until every expected result is out, then lets the pipeline settle.
  task drain();
    in_valid_i = 0;
    while (board.expected_cells.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    board.write_reg(idx, value);
  endtask

  function logic [31:0] air_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function logic [7:0] solid_value();
    if ($urandom_range(7) != 0) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  function logic [31:0] gain_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom;
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function logic [31:0] loss_value();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h1FFFF;
      default: return $urandom_range(65536);
    endcase
  endfunction

  task set_factors();
    reg_write(REG_VELOCITY_LOSS, loss_value());
    reg_write(REG_PRESSURE_LOSS, loss_value());
    reg_write(REG_VELOCITY_GAIN, gain_value());
    reg_write(REG_PRESSURE_GAIN, gain_value());
  endtask

  // One grid of cells with stray flushes; an aborted grid leaves results behind
  // that the next grid drops.
  task run_frame(bit abort);
    int n;
    for (int r = 0; r < board.grid_h(); r++)
      for (int c = 0; c < board.grid_w(); c++) begin
        if ($urandom_range(24) == 0) flush_one();
        send_item(CMD_CELL, air_value(), air_value(), air_value(), solid_value());
      end
    n = abort ? $urandom_range(board.grid_w()) : board.grid_w() + 1 + $urandom_range(2);
    repeat (n) flush_one();
  endtask

  initial begin
    int phase_items;
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_idle = 0; recv_idle = 0;

    // Smallest grid, extreme values, both commands, flush before and after the grid.
    reg_write(REG_GRID_WIDTH, 32'd3);
    reg_write(REG_GRID_HEIGHT, 32'd3);
    reg_write(REG_VELOCITY_GAIN, 32'h0001_0000);
    reg_write(REG_PRESSURE_GAIN, 32'hFFFF_0000);
    flush_one();
    send_item(CMD_CELL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    send_item(CMD_CELL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
    send_item(CMD_CELL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255);
    send_item(CMD_CELL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    send_item(CMD_CELL, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 8'd0);
    send_item(CMD_CELL, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 8'd1);
    send_item(CMD_CELL, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
    send_item(CMD_CELL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0);
    send_item(CMD_CELL, 32'hFFFF_FFFF, 32'h1, 32'h0, 8'd0);
    repeat (6) flush_one();
    drain();

    // A size write part way into a grid restarts it.
    send_item(CMD_CELL, air_value(), air_value(), air_value(), 8'd0);
    send_item(CMD_CELL, air_value(), air_value(), air_value(), 8'd0);
    drain();
    reg_write(REG_GRID_WIDTH, 32'd4);
    run_frame(0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 11 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 11 : 0;
      phase_items = 650 * (ph + 1);
      // Clamped sizes: a wide flat grid, a narrow tall one, then a small grid.
      case (ph)
        0: begin
          reg_write(REG_GRID_WIDTH, 32'd300);
          reg_write(REG_GRID_HEIGHT, 32'd0);
        end
        1: begin
          reg_write(REG_GRID_WIDTH, 32'd1);
          reg_write(REG_GRID_HEIGHT, 32'd256);
        end
        default: begin
          reg_write(REG_GRID_WIDTH, 32'd6);
          reg_write(REG_GRID_HEIGHT, 32'd4);
        end
      endcase
      set_factors();
      run_frame(0);
      while (items_sent < phase_items) begin
        if ($urandom_range(2) == 0) begin
          drain();
          reg_write(REG_GRID_WIDTH, $urandom_range(3, 10));
          reg_write(REG_GRID_HEIGHT, $urandom_range(3, 7));
          set_factors();
        end else if ($urandom_range(3) == 0) begin
          drain();
          set_factors();
        end
        run_frame($urandom_range(5) == 0);
      end
      drain();
    end

    in_valid_i = 0;
    while (board.expected_cells.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("sent %0d items (%0d flushes), checked %0d results over three idling phases",
             items_sent, flushes_sent, board.results_seen);
    $display("grid sizes from 3x3 up to clamped 256-wide and 256-tall grids, mismatches: %0d",
             board.errors);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
